// File: rtl/core/bhtp_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed hash table probe/store: shared package
// Transaction layouts, slot layout, command and register codes and the fixed
// constants of the replacement rule.
// ----------------------------------------------------------------------------
package bhtp_pkg;

    // Commands carried by a request transaction.
    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Bound kinds.
    localparam logic [1:0] EXACT_BOUND = 2'd3;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_VALUE = 1'b1;

    // Configuration reset values.
    localparam logic [14:0]        WIN_THR_RST  = 15'd31000;
    localparam logic signed [15:0] NO_VALUE_RST = 16'sd32001;

    // Signature position in the hash.
    localparam int SIG_SHIFT = 48;

    // Age bias of 259 reduced modulo 256; only the low eight bits matter.
    localparam logic [7:0] AGE_WRAP_BIAS = 8'd3;

    // Depth margins of the two skip rules.
    localparam logic signed [9:0] KEEP_DEPTH_MARGIN = 10'sd2;
    localparam logic signed [9:0] EVAL_ONLY_MARGIN  = 10'sd5;

    // Request transaction.
    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        hash;
        logic [7:0]         height;
        logic [15:0]        move_in;
        logic signed [15:0] score_in;
        logic signed [15:0] eval_in;
        logic signed [7:0]  depth_in;
        logic [1:0]         bound_in;
    } t_req;

    // Response transaction.
    typedef struct packed {
        logic               hit;
        logic [15:0]        move_out;
        logic signed [15:0] score_out;
        logic signed [15:0] eval_out;
        logic signed [7:0]  depth_out;
        logic [1:0]         bound_out;
    } t_rsp;

    // One table slot; age in bits 7..2 of age_bound, bound in bits 1..0.
    typedef struct packed {
        logic [15:0]        sig;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic signed [15:0] eval;
        logic signed [7:0]  depth;
        logic [7:0]         age_bound;
    } t_slot;

endpackage

// File: rtl/core/bhtp_stream_if.sv
// ----------------------------------------------------------------------------
// Bucketed hash table probe/store: stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bhtp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bhtp_slot_ram.sv
// ----------------------------------------------------------------------------
// Bucketed hash table probe/store: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhtp_slot_ram #(
    parameter int DEPTH  = 12288,
    parameter int ADDR_W = 14
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  bhtp_pkg::t_slot      i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr,
    output bhtp_pkg::t_slot      o_rdata
);

    bhtp_pkg::t_slot r_mem [DEPTH];
    bhtp_pkg::t_slot r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bucketed_hash_table_probe_store_core.sv
// ----------------------------------------------------------------------------
// Bucketed hash table probe/store core
// Set-associative search-result table: probe, store with depth/age
// replacement, and generation tick, scanned one slot per cycle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  i_req     in         valid/ready      command, hash, height, move, scores, depth, bound
//  o_rsp     out        valid/ready      hit, move, score, eval, depth, bound
//  i_cfg_*   in         write enable     register index, 16-bit data
//
//  After reset a clearing pass zeroes every slot, one per cycle, 2^INDEX_BITS *
//  SLOTS_PER_BUCKET slots (12288 by default); no request is taken meanwhile.
//  One read port visits the bucket slot by slot; k (1..SLOTS_PER_BUCKET) slots are read.
//  A probe hit returns its result from the scan; a probe miss goes on to a zero step, a store to a decide step.
//  A tick or an unused command goes straight from idle to the zero step.
//  A new request is taken while a result waits; the final step stalls only on a full output.
// ----------------------------------------------------------------------------
module bucketed_hash_table_probe_store_core #(
    parameter int INDEX_BITS       = 12,
    parameter int SLOTS_PER_BUCKET = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bhtp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bhtp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    bhtp_stream_if.sink                           i_req,
    bhtp_stream_if.source                         o_rsp
);

    localparam int NUM_SLOTS = (1 << INDEX_BITS) * SLOTS_PER_BUCKET;
    localparam int ADDR_W    = $clog2(NUM_SLOTS);
    localparam int SLOT_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_BUCKET - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_SLOTS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_ZERO   = 3'd4;

    // Control state.
    logic [2:0]              r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [5:0]              r_gen, n_gen;
    logic                    r_out_valid, n_out_valid;
    logic [14:0]             r_win_thr;
    logic signed [15:0]      r_no_value;

    // Payload state.
    bhtp_pkg::t_req          r_req, n_req;
    logic [ADDR_W-1:0]       r_base, n_base;
    bhtp_pkg::t_slot         r_vic, n_vic;
    logic [ADDR_W-1:0]       r_vic_addr, n_vic_addr;
    logic signed [9:0]       r_vic_rank, n_vic_rank;
    bhtp_pkg::t_rsp          r_out, n_out;

    // Memory ports.
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    bhtp_pkg::t_slot         ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    bhtp_pkg::t_slot         ram_rdata;

    // Datapath terms.
    logic                    in_fire;
    logic                    out_free;
    logic [ADDR_W-1:0]       in_base;
    logic [ADDR_W-1:0]       cur_addr;
    logic                    sig_match;
    logic [7:0]              age_diff;
    logic signed [9:0]       rank_cur;
    logic                    take_cur;
    logic signed [16:0]      thr17;
    logic signed [16:0]      height17;
    logic signed [16:0]      probe_v;
    logic signed [16:0]      probe_adj;
    logic signed [16:0]      store_v;
    logic signed [16:0]      store_adj;
    logic signed [15:0]      store_sat;
    logic signed [9:0]       req_depth10;
    logic signed [9:0]       vic_depth10;
    logic                    skip_shallow;
    logic                    skip_eval_only;

    bhtp_slot_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake terms.
    assign i_req.ready = (r_state == ST_IDLE);
    assign in_fire     = i_req.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Bucket base address and the slot under inspection.
    assign in_base  = ADDR_W'(ADDR_W'(i_req.data.hash[INDEX_BITS-1:0])
                              * ADDR_W'(SLOTS_PER_BUCKET));
    assign cur_addr = r_base + ADDR_W'(r_slot);
    assign sig_match = (ram_rdata.sig == r_req.hash[bhtp_pkg::SIG_SHIFT +: 16]);

    // Replacement rank: depth minus the masked age distance.
    assign age_diff = bhtp_pkg::AGE_WRAP_BIAS + {r_gen, 2'b00} - ram_rdata.age_bound;
    assign rank_cur = 10'(ram_rdata.depth) - $signed({2'b00, age_diff[7:2], 2'b00});
    assign take_cur = (r_slot == '0) || (r_vic_rank >= rank_cur);

    // Height adjustment of a probed score.
    assign thr17     = $signed({2'b00, r_win_thr});
    assign height17  = $signed({9'd0, r_req.height});
    assign probe_v   = 17'(ram_rdata.score);
    always_comb begin
        if (probe_v >= thr17) begin
            probe_adj = probe_v - height17;
        end else if (probe_v <= -thr17) begin
            probe_adj = probe_v + height17;
        end else begin
            probe_adj = probe_v;
        end
    end

    // Height adjustment and saturation of a stored score.
    assign store_v = 17'(r_req.score_in);
    always_comb begin
        if (store_v >= thr17) begin
            store_adj = store_v + height17;
        end else if (store_v <= -thr17) begin
            store_adj = store_v - height17;
        end else begin
            store_adj = store_v;
        end
        if (store_adj > 17'sd32767) begin
            store_sat = 16'sh7FFF;
        end else if (store_adj < -17'sd32768) begin
            store_sat = -16'sh8000;
        end else begin
            store_sat = store_adj[15:0];
        end
    end

    // Rules that leave the table untouched on a store.
    assign req_depth10    = 10'(r_req.depth_in);
    assign vic_depth10    = 10'(r_vic.depth);
    assign skip_shallow   = (r_req.bound_in != bhtp_pkg::EXACT_BOUND)
                            && (r_vic.sig == r_req.hash[bhtp_pkg::SIG_SHIFT +: 16])
                            && (req_depth10 < vic_depth10 - bhtp_pkg::KEEP_DEPTH_MARGIN);
    assign skip_eval_only = (r_req.score_in == r_no_value)
                            && (vic_depth10 > req_depth10 + bhtp_pkg::EVAL_ONLY_MARGIN)
                            && (r_vic.score != r_no_value)
                            && (r_vic.age_bound[7:2] == r_gen);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_slot      = r_slot;
        n_gen       = r_gen;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_req       = r_req;
        n_base      = r_base;
        n_vic       = r_vic;
        n_vic_addr  = r_vic_addr;
        n_vic_rank  = r_vic_rank;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = in_base;

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (in_fire) begin
                    n_req  = i_req.data;
                    n_base = in_base;
                    n_slot = '0;
                    case (i_req.data.command)
                        bhtp_pkg::CMD_PROBE, bhtp_pkg::CMD_STORE: begin
                            ram_re  = 1'b1;
                            n_state = ST_SCAN;
                        end
                        bhtp_pkg::CMD_TICK: begin
                            n_gen   = r_gen + 1'b1;
                            n_state = ST_ZERO;
                        end
                        default: begin
                            n_state = ST_ZERO;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (r_req.command == bhtp_pkg::CMD_PROBE) begin
                    if (sig_match) begin
                        // Hit: refresh the age, keep the bound, return the slot.
                        if (out_free) begin
                            ram_we                = 1'b1;
                            ram_wdata.age_bound   = {r_gen, ram_rdata.age_bound[1:0]};
                            n_out.hit             = 1'b1;
                            n_out.move_out        = ram_rdata.move;
                            n_out.score_out       = probe_adj[15:0];
                            n_out.eval_out        = ram_rdata.eval;
                            n_out.depth_out       = ram_rdata.depth;
                            n_out.bound_out       = ram_rdata.age_bound[1:0];
                            n_out_valid           = 1'b1;
                            n_state               = ST_IDLE;
                        end
                    end else if (r_slot == LAST_SLOT) begin
                        n_state = ST_ZERO;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_addr + 1'b1;
                        n_slot    = r_slot + 1'b1;
                    end
                end else begin
                    if (sig_match) begin
                        // Matching slot is always the target.
                        n_vic      = ram_rdata;
                        n_vic_addr = cur_addr;
                        n_state    = ST_DECIDE;
                    end else begin
                        // Keep the best victim so far; a later slot wins a tie.
                        if (take_cur) begin
                            n_vic      = ram_rdata;
                            n_vic_addr = cur_addr;
                            n_vic_rank = rank_cur;
                        end
                        if (r_slot == LAST_SLOT) begin
                            n_state = ST_DECIDE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = cur_addr + 1'b1;
                            n_slot    = r_slot + 1'b1;
                        end
                    end
                end
            end

            ST_DECIDE: begin
                if (out_free) begin
                    if (!skip_shallow && !skip_eval_only) begin
                        ram_we              = 1'b1;
                        ram_waddr           = r_vic_addr;
                        ram_wdata.sig       = r_req.hash[bhtp_pkg::SIG_SHIFT +: 16];
                        ram_wdata.move      = r_req.move_in;
                        ram_wdata.score     = store_sat;
                        ram_wdata.eval      = r_req.eval_in;
                        ram_wdata.depth     = r_req.depth_in;
                        ram_wdata.age_bound = {r_gen, r_req.bound_in};
                    end
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            ST_ZERO: begin
                if (out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_slot      <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_slot      <= n_slot;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_thr  <= bhtp_pkg::WIN_THR_RST;
            r_no_value <= bhtp_pkg::NO_VALUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bhtp_pkg::CFG_WIN_THR:  r_win_thr  <= i_cfg_data[14:0];
                bhtp_pkg::CFG_NO_VALUE: r_no_value <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_base     <= n_base;
        r_vic      <= n_vic;
        r_vic_addr <= n_vic_addr;
        r_vic_rank <= n_vic_rank;
        r_out      <= n_out;
    end

    // A result is only produced by the final step of a transaction.
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_SCAN || $past(r_state) == ST_DECIDE
                                || $past(r_state) == ST_ZERO))
        else $error("result produced outside a final step");

    // The memory is never written while waiting for a request.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != ST_IDLE && r_state != ST_ZERO))
        else $error("slot memory written while idle");

    // The scan never runs past the last slot of a bucket.
    a_slot_in_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_slot <= LAST_SLOT))
        else $error("slot index beyond bucket");

    // A full output register that is not taken keeps its result.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost or changed");

endmodule

// File: bench/bhtp_table_checker.sv
// ----------------------------------------------------------------------------
// Bucketed hash table probe/store: transaction checker
// Watches the configuration port and both channels. It keeps its own copy of
// the table and predicts the response of every accepted request. Each
// accepted response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bhtp_table_checker
    import bhtp_pkg::*;
#(
    parameter int INDEX_BITS       = 12,
    parameter int SLOTS_PER_BUCKET = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_req                  i_req_data,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  t_rsp                  i_rsp_data,
    output int                    o_pending,
    output int                    o_failures
);

    localparam int NUM_SLOTS = (1 << INDEX_BITS) * SLOTS_PER_BUCKET;

    // The age distance is taken modulo 256, so a bias of 259 acts as 3.
    localparam logic [7:0] AGE_BIAS     = 8'd3;
    localparam logic [7:0] AGE_FIELD    = 8'hFC;
    localparam int         KEEP_MARGIN  = 2;
    localparam int         EVAL_MARGIN  = 5;
    localparam logic [7:0] GEN_STEP     = 8'd4;

    // Model copy of the table and of the registers.
    logic [15:0]        tbl_sig       [NUM_SLOTS];
    logic [15:0]        tbl_move      [NUM_SLOTS];
    logic signed [15:0] tbl_score     [NUM_SLOTS];
    logic [15:0]        tbl_eval      [NUM_SLOTS];
    logic signed [7:0]  tbl_depth     [NUM_SLOTS];
    logic [7:0]         tbl_age_bound [NUM_SLOTS];
    logic [7:0]         generation;
    logic [14:0]        win_thr;
    logic signed [15:0] no_value;

    t_rsp expected_rsp [$];
    t_rsp want;
    int   failures;
    int   pending;

    assign o_failures = failures;
    assign o_pending  = pending;

    // Replacement rank: depth less the age distance from the current generation.
    function automatic int slot_rank(input int s);
        logic [7:0] age;
        age = (AGE_BIAS + generation - tbl_age_bound[s]) & AGE_FIELD;
        return int'(tbl_depth[s]) - int'(age);
    endfunction

    // Apply one request to the table copy and return the response it causes.
    function automatic t_rsp apply_request(input t_req r);
        t_rsp        res;
        logic [15:0] sig;
        int          base;
        int          m;
        int          s;
        int          victim;
        int          target;
        int          value;
        int          dep;
        int          stored;
        int          v;
        bit          found;
        bit          skip;
        res   = '0;
        sig   = r.hash[SIG_SHIFT +: 16];
        base  = int'(r.hash[INDEX_BITS-1:0]) * SLOTS_PER_BUCKET;
        found = 1'b0;
        case (r.command)
            CMD_PROBE: begin
                // First slot with a matching signature wins.
                for (m = 0; m < SLOTS_PER_BUCKET; m++) begin
                    s = base + m;
                    if (!found && tbl_sig[s] == sig) begin
                        found = 1'b1;
                        tbl_age_bound[s] = generation | (tbl_age_bound[s] & 8'h03);
                        v = int'(tbl_score[s]);
                        if (v >= int'(win_thr))
                            v = v - int'(r.height);
                        else if (v <= -int'(win_thr))
                            v = v + int'(r.height);
                        res.hit       = 1'b1;
                        res.move_out  = tbl_move[s];
                        res.score_out = v[15:0];
                        res.eval_out  = tbl_eval[s];
                        res.depth_out = tbl_depth[s];
                        res.bound_out = tbl_age_bound[s][1:0];
                    end
                end
            end
            CMD_STORE: begin
                // Scan until a match; meanwhile the weakest slot so far is the
                // victim, with a later slot taking a tie.
                victim = base;
                m = 0;
                while (m < SLOTS_PER_BUCKET && tbl_sig[base + m] != sig) begin
                    if (slot_rank(victim) >= slot_rank(base + m))
                        victim = base + m;
                    m++;
                end
                target = (m < SLOTS_PER_BUCKET) ? base + m : victim;
                value  = int'($signed(r.score_in));
                dep    = int'($signed(r.depth_in));

                // Shallow non-exact overwrite, or eval-only over a deeper fresh entry.
                skip = (r.bound_in != EXACT_BOUND && tbl_sig[target] == sig
                        && dep < int'(tbl_depth[target]) - KEEP_MARGIN)
                    || (value == int'(no_value)
                        && int'(tbl_depth[target]) > dep + EVAL_MARGIN
                        && tbl_score[target] != no_value
                        && (tbl_age_bound[target] & AGE_FIELD) == generation);

                if (!skip) begin
                    stored = value;
                    if (value >= int'(win_thr))
                        stored = value + int'(r.height);
                    else if (value <= -int'(win_thr))
                        stored = value - int'(r.height);
                    if (stored > 32767)
                        stored = 32767;
                    if (stored < -32768)
                        stored = -32768;
                    tbl_depth[target]     = r.depth_in;
                    tbl_age_bound[target] = generation | {6'd0, r.bound_in};
                    tbl_score[target]     = stored[15:0];
                    tbl_eval[target]      = r.eval_in;
                    tbl_move[target]      = r.move_in;
                    tbl_sig[target]       = sig;
                end
            end
            CMD_TICK: begin
                generation = generation + GEN_STEP;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // One field comparison; a difference counts as a failure.
    task automatic flag_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            failures++;
        end
    endtask

    initial begin
        failures = 0;
        pending  = 0;
    end

    // Sample the ports at each rising edge: configuration, response, request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                tbl_sig[s]       = '0;
                tbl_move[s]      = '0;
                tbl_score[s]     = '0;
                tbl_eval[s]      = '0;
                tbl_depth[s]     = '0;
                tbl_age_bound[s] = '0;
            end
            generation = '0;
            win_thr    = WIN_THR_RST;
            no_value   = NO_VALUE_RST;
            expected_rsp.delete();
            pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIN_THR:  win_thr = i_cfg_data[14:0];
                    CFG_NO_VALUE: no_value = i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // A response accepted now belongs to an earlier request.
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("response transaction with no request outstanding");
                    failures++;
                end else begin
                    want = expected_rsp.pop_front();
                    flag_field("hit", want.hit, i_rsp_data.hit);
                    flag_field("move_out", want.move_out, i_rsp_data.move_out);
                    flag_field("score_out", $signed(want.score_out),
                               $signed(i_rsp_data.score_out));
                    flag_field("eval_out", $signed(want.eval_out),
                               $signed(i_rsp_data.eval_out));
                    flag_field("depth_out", $signed(want.depth_out),
                               $signed(i_rsp_data.depth_out));
                    flag_field("bound_out", want.bound_out, i_rsp_data.bound_out);
                end
            end

            if (i_req_valid && i_req_ready)
                expected_rsp.push_back(apply_request(i_req_data));

            pending = expected_rsp.size();
        end
    end

endmodule

// File: bench/tb_bucketed_hash_table_probe_store_core.sv
// ----------------------------------------------------------------------------
// Bucketed hash table probe/store core: testbench top
// Drives reset, register writes and request transactions, and stalls the
// response channel at random. A directed opening covers the corner cases of
// probe, store, skip rules and generation tick; random phases follow under
// several register settings, on a small pool of buckets and signatures so
// that buckets fill, collide and evict. The checker gives the failure count.
// ----------------------------------------------------------------------------
module tb_bucketed_hash_table_probe_store_core;
    import bhtp_pkg::*;

    localparam int         INDEX_BITS       = 12;
    localparam int         SLOTS_PER_BUCKET = 3;
    localparam int         PHASE_ITEMS      = 280;
    localparam int         NUM_PHASES       = 5;
    localparam logic [1:0] CMD_UNUSED       = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    pending;
    int                    failures;
    bit                    calm;
    int                    thr_now;
    int                    nv_now;

    // Small pools so that random keys meet in the same buckets.
    logic [11:0] bucket_pool [6] = '{12'h000, 12'h001, 12'hFFF, 12'hA5A, 12'h555, 12'h3C7};
    logic [15:0] sig_pool    [7] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h1234,
                                     16'h7FFE, 16'hC3C3, 16'h5A5A};

    bhtp_stream_if #(.T(t_req)) req_if ();
    bhtp_stream_if #(.T(t_rsp)) rsp_if ();

    bucketed_hash_table_probe_store_core #(
        .INDEX_BITS       (INDEX_BITS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    bhtp_table_checker #(
        .INDEX_BITS       (INDEX_BITS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (req_if.valid),
        .i_req_ready (req_if.ready),
        .i_req_data  (req_if.data),
        .i_rsp_valid (rsp_if.valid),
        .i_rsp_ready (rsp_if.ready),
        .i_rsp_data  (rsp_if.data),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up after a generous bound that leaves room for the clearing pass.
    initial begin
        #8000000;
        $display("FAIL bucketed_hash_table_probe_store_core");
        $finish;
    end

    // Response back-pressure, off during the calm stretch.
    always @(negedge i_clk) begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 14);
    end

    // Key with a pooled bucket and signature and random bits in between.
    function automatic logic [63:0] pool_key(input int b, input int s);
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        return {sig_pool[s], rnd[35:0], bucket_pool[b]};
    endfunction

    // Score picked around the current threshold, the no-value code and the extremes.
    function automatic int pick_score();
        int v;
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = thr_now + int'($urandom_range(0, 4)) - 2;
            2: v = -thr_now + int'($urandom_range(0, 4)) - 2;
            3: v = nv_now;
            4: v = 32767;
            5: v = -32768;
            default: v = int'($urandom_range(0, 1000)) - 500;
        endcase
        return v;
    endfunction

    // Send one request transaction, with random idle cycles ahead of it outside the calm stretch.
    task automatic issue(input logic [1:0] cmd, input logic [63:0] key, input int ht,
                         input int mv, input int sc, input int ev, input int dp,
                         input int bd);
        t_req r;
        r.command  = cmd;
        r.hash     = key;
        r.height   = ht[7:0];
        r.move_in  = mv[15:0];
        r.score_in = sc[15:0];
        r.eval_in  = ev[15:0];
        r.depth_in = dp[7:0];
        r.bound_in = bd[1:0];
        if (!calm) begin
            while ($urandom_range(99) < 14) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write; the enable is lowered again before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_WIN_THR)
            thr_now = int'(val[14:0]);
        else
            nv_now = int'($signed(val));
    endtask

    // Wait until every outstanding response has arrived, then idle before returning.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Random requests on pooled keys, with some noise keys and unused commands.
    task automatic random_phase(input int phase);
        logic [63:0] key;
        logic [1:0]  cmd;
        int          roll;
        int          dp;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            calm = (phase == 2) && (n < 250);
            roll = $urandom_range(0, 99);
            if (roll < 42)
                cmd = CMD_PROBE;
            else if (roll < 88)
                cmd = CMD_STORE;
            else if (roll < 97)
                cmd = CMD_TICK;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(0, 9) == 0)
                key = {$urandom, $urandom};
            else
                key = pool_key($urandom_range(0, 5), $urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0)
                dp = int'($urandom_range(0, 255)) - 128;
            else
                dp = int'($urandom_range(0, 40)) - 8;
            issue(cmd, key, $urandom_range(0, 255), $urandom_range(0, 65535),
                  pick_score(), int'($urandom_range(0, 65535)) - 32768, dp,
                  $urandom_range(0, 3));
        end
        calm = 1'b0;
    endtask

    // Directed opening under the reset register values.
    task automatic directed_part();
        logic [63:0] kb;
        logic [63:0] kc;
        logic [63:0] kd;
        logic [63:0] ke [4];
        kb = {16'h8001, 36'h0, 12'h001};
        kc = {16'h1234, 36'hF_0F0F_0F0F, 12'h002};
        kd = {16'h5A5A, 36'h9_8765_4321, 12'h003};
        for (int k = 0; k < 4; k++)
            ke[k] = {8'h00, 8'(k + 1), 36'h0_0000_1111, 12'h7A5};

        // A cleared slot has signature zero, so a key with zero top bits hits.
        issue(CMD_PROBE, 64'h0, 0, 0, 0, 0, 0, 0);
        issue(CMD_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 255, 0, 0, 0, 0, 0);

        // Extreme fields, with saturation of the shifted score both ways.
        issue(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 255, 65535, 32767, -32768, 127, 3);
        issue(CMD_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 255, 0, 0, 0, 0, 0);
        issue(CMD_STORE, kb, 255, 0, -32768, 32767, -128, 0);
        issue(CMD_PROBE, kb, 7, 0, 0, 0, 0, 0);

        // Shallow non-exact overwrite of the same signature is dropped.
        issue(CMD_STORE, kc, 3, 16'h1111, 31000, 40, 20, 3);
        issue(CMD_STORE, kc, 3, 16'h2222, 5, 50, 10, 2);
        issue(CMD_PROBE, kc, 3, 0, 0, 0, 0, 0);

        // Eval-only store over a deeper entry of this generation is dropped.
        issue(CMD_STORE, kd, 0, 16'h3333, 100, -7, 30, 1);
        issue(CMD_STORE, kd, 0, 16'h4444, 32001, 9, 5, 3);
        issue(CMD_PROBE, kd, 0, 0, 0, 0, 0, 0);

        // After a tick the same store goes through, shifted by the height.
        issue(CMD_TICK, 64'h0, 0, 0, 0, 0, 0, 0);
        issue(CMD_STORE, kd, 10, 16'h5555, 32001, 9, 5, 3);
        issue(CMD_PROBE, kd, 10, 0, 0, 0, 0, 0);

        // Unused command code.
        issue(CMD_UNUSED, 64'hDEAD_BEEF_0123_4567, 77, 16'hABCD, -1, 1, -1, 2);

        // Four signatures into one three-slot bucket force an eviction.
        issue(CMD_STORE, ke[0], 0, 16'h0101, 10, 1, 9, 1);
        issue(CMD_STORE, ke[1], 0, 16'h0202, 20, 2, 3, 2);
        issue(CMD_STORE, ke[2], 0, 16'h0303, 30, 3, 12, 3);
        issue(CMD_STORE, ke[3], 0, 16'h0404, -31000, 4, 7, 0);
        for (int k = 0; k < 4; k++)
            issue(CMD_PROBE, ke[k], 50, 0, 0, 0, 0, 0);
    endtask

    // Main sequence: reset, directed opening, then random phases.
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        calm         = 1'b0;
        thr_now      = int'(WIN_THR_RST);
        nv_now       = int'(NO_VALUE_RST);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_part();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                1: begin
                    write_reg(CFG_WIN_THR, 16'd0);
                    write_reg(CFG_NO_VALUE, 16'h8000);
                end
                2: begin
                    write_reg(CFG_WIN_THR, 16'd32767);
                    write_reg(CFG_NO_VALUE, 16'h7FFF);
                end
                3: begin
                    // The top bit of the threshold write is not part of the register.
                    write_reg(CFG_WIN_THR, {1'b1, 15'd100});
                    write_reg(CFG_NO_VALUE, 16'($urandom_range(0, 600) - 300));
                end
                4: begin
                    write_reg(CFG_WIN_THR, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_NO_VALUE, 16'd0);
                end
                default: begin
                end
            endcase
            random_phase(phase);
        end
        drain();
        repeat (12) @(negedge i_clk);

        if (failures == 0)
            $display("PASS bucketed_hash_table_probe_store_core");
        else
            $display("FAIL bucketed_hash_table_probe_store_core");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/bhtp_pkg.sv
rtl/core/bhtp_stream_if.sv
rtl/core/bhtp_slot_ram.sv
rtl/core/bucketed_hash_table_probe_store_core.sv
bench/bhtp_table_checker.sv
bench/tb_bucketed_hash_table_probe_store_core.sv
